// ----- hdl/sgmpa_pkg.sv -----
// ----------------------------------------------------------------------------
// sgmpa_pkg
// Shared types and constants of the path cost aggregation core: beat
// payloads, configuration register indexes and cost widths.
// ----------------------------------------------------------------------------
package sgmpa_pkg;

	// widths of the cost, plane and configuration words, and the read port count
	localparam int COST_W   = 17;
	localparam int IN_W     = 16;
	localparam int PLANE_W  = 6;
	localparam int CFG_W    = 16;
	localparam int CFG_AW   = 2;
	localparam int RD_PORTS = 3;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// read port roles of the cost store
	localparam int RD_CTR = 0;
	localparam int RD_UP  = 1;
	localparam int RD_DN  = 2;

	// configuration register indexes
	typedef enum logic [CFG_AW-1:0] {
		CFG_PLANE_COUNT = 2'd0,
		CFG_SMALL_STEP  = 2'd1,
		CFG_BIG_STEP    = 2'd2,
		CFG_UNSEEN_COST = 2'd3
	} sgmpa_cfg_idx_t;

	// input beat: one plane cost of one pixel
	typedef struct packed {
		logic [IN_W-1:0]    cost;
		logic               unseen;
		logic [PLANE_W-1:0] plane;
		logic               path_start;
	} sgmpa_in_t;

	// result beat
	typedef struct packed {
		logic [COST_W-1:0]  path_cost;
		logic [PLANE_W-1:0] plane_out;
		logic               pixel_done;
	} sgmpa_out_t;

endpackage

// ----- hdl/sgmpa_cost_ram.sv -----
// ----------------------------------------------------------------------------
// sgmpa_cost_ram
// One bank of plane costs: a single write port and three registered read
// ports, built as three copies that share every write.
// ----------------------------------------------------------------------------
module sgmpa_cost_ram
	import sgmpa_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [COST_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr [RD_PORTS],
	output logic [COST_W-1:0] rd_data [RD_PORTS]
);

	logic [COST_W-1:0] mem [RD_PORTS][DEPTH];

	// every copy takes the same write, each serves one read port
	always_ff @(posedge clk) begin
		for (int k = 0; k < RD_PORTS; k++) begin
			if (wr_en) begin
				mem[k][wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_data[k] <= mem[k][rd_addr[k]];
			end
		end
	end

endmodule

// ----- hdl/sgm_path_cost_aggregation_core.sv -----
// ----------------------------------------------------------------------------
// sgm_path_cost_aggregation_core
// Semi-global matching recurrence along one path: each plane cost of a pixel
// gets the cheapest of same plane, neighbour plane plus small step, or floor
// plus big step, less the previous pixel's floor; a path start passes its cost through.
//
//   channel  | signals                          | beat
//   ---------+----------------------------------+---------------------------
//   cost     | cost_valid cost_ready cost_data  | one plane cost of a pixel
//   res      | res_valid res_ready res_data     | one aggregated plane cost
//   cfg      | cfg_we cfg_index cfg_data        | one register write
//
// One beat per cycle sustained while res is not stalled; a taken beat goes
// through the s1 register (store read at the accepting edge) and then the
// result register, which presents it on res.
// The rate is set by the three-read cost store, which is replicated per read.
// Reset clears control state only; the cost stores need no clearing pass.
// Backpressure on res stalls s1, and cost_ready drops only while s1 is held.
// ----------------------------------------------------------------------------
module sgm_path_cost_aggregation_core
	import sgmpa_pkg::*;
#(
	parameter int MAX_PLANES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cost_valid,
	output logic              cost_ready,
	input  sgmpa_in_t         cost_data,
	output logic              res_valid,
	input  logic              res_ready,
	output sgmpa_out_t        res_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam logic [8:0] MaxCnt = 9'(MAX_PLANES);

	// configuration registers
	logic [6:0]      plane_count_q;
	logic [IN_W-1:0] small_step_q;
	logic [IN_W-1:0] big_step_q;
	logic [IN_W-1:0] unseen_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= 7'd64;
			small_step_q  <= 16'd256;
			big_step_q    <= 16'd2048;
			unseen_cost_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (sgmpa_cfg_idx_t'(cfg_index))
				CFG_PLANE_COUNT: plane_count_q <= cfg_data[6:0];
				CFG_SMALL_STEP:  small_step_q  <= cfg_data;
				CFG_BIG_STEP:    big_step_q    <= cfg_data;
				CFG_UNSEEN_COST: unseen_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	logic s1_valid;
	logic s1_fire;
	logic res_valid_q;
	logic cost_accept;

	assign s1_fire     = s1_valid && (!res_valid_q || res_ready);
	assign cost_ready  = !s1_valid || s1_fire;
	assign cost_accept = cost_valid && cost_ready;

	// plane clamping and neighbour indexes
	logic [8:0] cnt9, last9, pl9, up9, dn9;

	always_comb begin
		cnt9 = (plane_count_q == 7'd0) ? 9'd1 : {2'b00, plane_count_q};
		if (cnt9 > MaxCnt) begin
			cnt9 = MaxCnt;
		end
		last9 = cnt9 - 9'd1;
		pl9   = {3'b000, cost_data.plane};
		if (pl9 > last9) begin
			pl9 = last9;
		end
		up9 = (pl9 < last9) ? pl9 + 9'd1 : last9;
		dn9 = (pl9 != 9'd0) ? pl9 - 9'd1 : 9'd0;
	end

	logic [IW-1:0] rd_addr [RD_PORTS];
	assign rd_addr[RD_CTR] = pl9[IW-1:0];
	assign rd_addr[RD_UP]  = up9[IW-1:0];
	assign rd_addr[RD_DN]  = dn9[IW-1:0];

	// s1 register
	logic [IN_W-1:0]    filled_s1;
	logic               start_s1;
	logic               done_s1;
	logic               multi_s1;
	logic [PLANE_W-1:0] plane_s1;
	logic [IW-1:0]      addr_s1 [RD_PORTS];
	logic               fwd_hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (cost_ready) begin
			s1_valid   <= cost_valid;
			fwd_hit_s1 <= cost_valid && s1_fire && done_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cost_accept) begin
			filled_s1 <= cost_data.unseen ? unseen_cost_q : cost_data.cost;
			start_s1  <= cost_data.path_start;
			done_s1   <= (pl9 == last9);
			multi_s1  <= (last9 != 9'd0);
			plane_s1  <= pl9[PLANE_W-1:0];
			addr_s1   <= rd_addr;
		end
	end

	// per plane: bank that holds the previous pixel's value, and written flags
	logic [MAX_PLANES-1:0] loc_q;
	logic [MAX_PLANES-1:0] wr_q;
	logic [MAX_PLANES-1:0] plane_hot;
	logic                  wr_bank;

	always_comb begin
		plane_hot = '0;
		plane_hot[addr_s1[RD_CTR]] = 1'b1;
	end

	assign wr_bank = !loc_q[addr_s1[RD_CTR]];

	// two banks of plane costs
	logic [COST_W-1:0] result;
	logic [COST_W-1:0] rd0 [RD_PORTS];
	logic [COST_W-1:0] rd1 [RD_PORTS];

	sgmpa_cost_ram #(.DEPTH(MAX_PLANES)) u_bank0 (
		.clk     (clk),
		.wr_en   (s1_fire && !wr_bank),
		.wr_addr (addr_s1[RD_CTR]),
		.wr_data (result),
		.rd_en   (cost_accept),
		.rd_addr (rd_addr),
		.rd_data (rd0)
	);

	sgmpa_cost_ram #(.DEPTH(MAX_PLANES)) u_bank1 (
		.clk     (clk),
		.wr_en   (s1_fire && wr_bank),
		.wr_addr (addr_s1[RD_CTR]),
		.wr_data (result),
		.rd_en   (cost_accept),
		.rd_addr (rd_addr),
		.rd_data (rd1)
	);

	// last write, forwarded when it closed a pixel at the edge of the read
	logic [IW-1:0]     fwd_plane_q;
	logic [COST_W-1:0] fwd_cost_q;

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_plane_q <= addr_s1[RD_CTR];
			fwd_cost_q  <= result;
		end
	end

	logic [COST_W-1:0] prev_val [RD_PORTS];

	always_comb begin
		for (int k = 0; k < RD_PORTS; k++) begin
			prev_val[k] = loc_q[addr_s1[k]] ? rd1[k] : rd0[k];
			if (fwd_hit_s1 && (fwd_plane_q == addr_s1[k])) begin
				prev_val[k] = fwd_cost_q;
			end
		end
	end

	// recurrence
	logic [COST_W-1:0] prev_floor_q;
	logic [COST_W-1:0] run_floor_q;
	logic [COST_W:0]   big_sum, best0, nb_sum, best;
	logic [COST_W-1:0] nb;
	logic signed [20:0] sum;
	logic [COST_W-1:0] clamped;

	always_comb begin
		big_sum = {1'b0, prev_floor_q} + {2'b00, big_step_q};
		best0   = ({1'b0, prev_val[RD_CTR]} < big_sum) ? {1'b0, prev_val[RD_CTR]} : big_sum;
		nb      = (prev_val[RD_UP] < prev_val[RD_DN]) ? prev_val[RD_UP] : prev_val[RD_DN];
		nb_sum  = {1'b0, nb} + {2'b00, small_step_q};
		best    = (multi_s1 && (nb_sum < best0)) ? nb_sum : best0;
		sum     = $signed({5'b0, filled_s1}) + $signed({3'b0, best})
			- $signed({4'b0, prev_floor_q});
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > $signed({4'b0, COST_MAX})) begin
			clamped = COST_MAX;
		end else begin
			clamped = sum[COST_W-1:0];
		end
		result = start_s1 ? {1'b0, filled_s1} : clamped;
	end

	// floors and bank bookkeeping
	logic [COST_W-1:0] new_floor;
	assign new_floor = (result < run_floor_q) ? result : run_floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_floor_q <= '0;
			run_floor_q  <= COST_MAX;
			loc_q        <= '0;
			wr_q         <= '0;
		end else if (s1_fire) begin
			if (done_s1) begin
				prev_floor_q <= new_floor;
				run_floor_q  <= COST_MAX;
				loc_q        <= loc_q ^ (wr_q | plane_hot);
				wr_q         <= '0;
			end else begin
				run_floor_q <= new_floor;
				wr_q        <= wr_q | plane_hot;
			end
		end
	end

	// result register
	sgmpa_out_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res_q.path_cost  <= result;
			res_q.plane_out  <= plane_s1;
			res_q.pixel_done <= done_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// checks
	a_done_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && done_s1 |=> (wr_q == '0) && (run_floor_q == COST_MAX))
		else $error("pixel end did not clear written flags and running floor");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_s1 |-> s1_valid)
		else $error("forward hit without an item in s1");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |-> cost_ready)
		else $error("empty s1 refused a beat");

	a_result_follows_fire: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_valid_q && (res_q.path_cost == $past(result)))
		else $error("result register missed a fired item");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the path cost aggregation core. A queue-fed driver
// offers plane cost beats with random gaps, a monitor takes result beats with
// random stalls, and an in-bench copy of the path recurrence predicts every
// result. A short directed run covers the extremes, out-of-order planes,
// planes beyond the count and a stale floor. Random phases follow, each with
// its own register settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sgmpa_pkg::*;

	localparam int MAX_PLANES  = 64;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 175;
	localparam int CYCLE_LIMIT = 500000;

	logic              clk;
	logic              arst_n     = 1'b0;
	logic              cost_valid = 1'b0;
	logic              cost_ready;
	sgmpa_in_t         cost_data  = '0;
	logic              res_valid;
	logic              res_ready  = 1'b0;
	sgmpa_out_t        res_data;
	logic              cfg_we     = 1'b0;
	logic [CFG_AW-1:0] cfg_index  = CFG_PLANE_COUNT;
	logic [CFG_W-1:0]  cfg_data   = '0;

	// beats waiting to be offered and results waiting to arrive
	sgmpa_in_t  pending_cost_q[$];
	sgmpa_out_t expected_path_cost_q[$];

	// idling control, set between phases
	int send_gap_max = 0;
	int recv_gap_max = 0;
	int send_wait    = 0;
	int recv_wait    = 0;
	int stall_left   = 0;
	int results_seen = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	// predictor copy of the registers and path state
	logic [6:0]        cfg_planes      = 7'd64;
	logic [15:0]       cfg_small_step  = 16'd256;
	logic [15:0]       cfg_big_step    = 16'd2048;
	logic [15:0]       cfg_unseen_cost = 16'hFFFF;
	logic [COST_W-1:0] prior_cost[MAX_PLANES];
	logic [COST_W-1:0] fresh_cost[MAX_PLANES];
	logic [COST_W-1:0] prior_floor     = '0;
	logic [COST_W-1:0] pixel_floor     = COST_MAX;

	sgmpa_out_t expected_beat;

	sgm_path_cost_aggregation_core #(
		.MAX_PLANES(MAX_PLANES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cost_valid (cost_valid),
		.cost_ready (cost_ready),
		.cost_data  (cost_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// path recurrence for one accepted beat, updates the path state
	function automatic sgmpa_out_t aggregate_cost(input sgmpa_in_t beat);
		int n, top, p, filled, fl, best, up, dn, sum;
		sgmpa_out_t outcome;
		n = int'(cfg_planes);
		if (n < 1) n = 1;
		if (n > MAX_PLANES) n = MAX_PLANES;
		top = n - 1;
		p = int'(beat.plane);
		if (p > top) p = top;
		filled = beat.unseen ? int'(cfg_unseen_cost) : int'(beat.cost);
		fl = int'(prior_floor);
		if (beat.path_start) begin
			sum = filled;
		end else begin
			best = int'(prior_cost[p]);
			if (fl + int'(cfg_big_step) < best) best = fl + int'(cfg_big_step);
			// neighbour planes, clamped at both ends
			if (n > 1) begin
				up = int'(prior_cost[p < top ? p + 1 : top]);
				dn = int'(prior_cost[p > 0 ? p - 1 : 0]);
				if (dn < up) up = dn;
				if (up + int'(cfg_small_step) < best) best = up + int'(cfg_small_step);
			end
			sum = filled + best - fl;
			if (sum < 0) sum = 0;
			if (sum > int'(COST_MAX)) sum = int'(COST_MAX);
		end
		fresh_cost[p] = COST_W'(sum);
		if (sum < int'(pixel_floor)) pixel_floor = COST_W'(sum);
		outcome.path_cost  = COST_W'(sum);
		outcome.plane_out  = PLANE_W'(p);
		outcome.pixel_done = (p == top);
		// pixel end: this pixel becomes the previous one
		if (p == top) begin
			prior_cost  = fresh_cost;
			prior_floor = pixel_floor;
			pixel_floor = COST_MAX;
		end
		return outcome;
	endfunction

	function automatic logic [15:0] draw_cost();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 511));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_beat(input logic [15:0] c, input bit u, input logic [5:0] p,
	                         input bit s);
		sgmpa_in_t beat;
		beat.cost       = c;
		beat.unseen     = u;
		beat.plane      = p;
		beat.path_start = s;
		pending_cost_q.insert(pending_cost_q.size(), beat);
	endtask

	// one pixel: every plane below the last at least once, then the last plane
	task automatic push_pixel(input bit path_head, input int style, output int beats);
		int n, i, j, tmp, final_plane;
		int planes[$];
		bit head;
		n = int'(cfg_planes);
		if (n < 1) n = 1;
		if (n > MAX_PLANES) n = MAX_PLANES;
		for (i = 0; i < n - 1; i++) planes.insert(planes.size(), i);
		// out-of-order planes, sometimes with a repeated plane
		if (style == 1 && n > 1) begin
			for (i = n - 2; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = planes[i];
				planes[i] = planes[j];
				planes[j] = tmp;
			end
			if ($urandom_range(0, 1))
				planes.insert(planes.size(), planes[$urandom_range(0, n - 2)]);
		end
		// last plane given as an index beyond the count
		final_plane = (style == 2 && n < MAX_PLANES) ? $urandom_range(n, 63) : n - 1;
		planes.insert(planes.size(), final_plane);
		head = path_head || ($urandom_range(0, 9) == 0);
		foreach (planes[k])
			push_beat(draw_cost(), $urandom_range(0, 7) == 0, 6'(planes[k]),
			          head || ($urandom_range(0, 15) == 0));
		beats = planes.size();
	endtask

	task automatic write_reg(input sgmpa_cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PLANE_COUNT: cfg_planes      = val[6:0];
			CFG_SMALL_STEP:  cfg_small_step  = val;
			CFG_BIG_STEP:    cfg_big_step    = val;
			CFG_UNSEEN_COST: cfg_unseen_cost = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// wait until every queued beat is taken and every result is back
	task automatic wait_idle();
		@(negedge clk);
		while (pending_cost_q.size() != 0 || cost_valid || expected_path_cost_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [15:0] draw_step();
		return ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
	endfunction

	// driver: offers cost beats, predicts on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_valid <= 1'b0;
		end else begin
			if (cost_valid && cost_ready) begin
				expected_path_cost_q.insert(expected_path_cost_q.size(),
				                            aggregate_cost(cost_data));
				send_wait = $urandom_range(0, send_gap_max);
			end
			if (!cost_valid || cost_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					cost_valid <= 1'b0;
				end else if (pending_cost_q.size() == 0) begin
					cost_valid <= 1'b0;
				end else begin
					cost_data  <= pending_cost_q.pop_front();
					cost_valid <= 1'b1;
				end
			end
		end
	end

	// monitor: takes result beats and checks them in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				results_seen++;
				if (expected_path_cost_q.size() == 0) begin
					if (mismatches < 10)
						$display("result with nothing expected: cost %0d plane %0d done %0b",
						         res_data.path_cost, res_data.plane_out, res_data.pixel_done);
					mismatches++;
				end else begin
					expected_beat = expected_path_cost_q.pop_front();
					if (res_data.path_cost !== expected_beat.path_cost ||
					    res_data.plane_out !== expected_beat.plane_out ||
					    res_data.pixel_done !== expected_beat.pixel_done) begin
						if (mismatches < 10)
							$display("mismatch %0d: cost %0d/%0d plane %0d/%0d done %0b/%0b",
							         results_seen, expected_beat.path_cost, res_data.path_cost,
							         expected_beat.plane_out, res_data.plane_out,
							         expected_beat.pixel_done, res_data.pixel_done);
						mismatches++;
					end
				end
				recv_wait = $urandom_range(0, recv_gap_max);
				// long hold-off so the core fills and stalls its input
				if (results_seen % 450 == 250) stall_left = 300;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus
	initial begin
		int phase, pushed, beats, count_set, style;
		bit first, paused;
		logic [15:0] s_step, b_step, u_cost;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: four planes, known penalties
		send_gap_max = 2;
		recv_gap_max = 2;
		write_reg(CFG_PLANE_COUNT, 16'd4);
		write_reg(CFG_SMALL_STEP, 16'd256);
		write_reg(CFG_BIG_STEP, 16'd2048);
		write_reg(CFG_UNSEEN_COST, 16'd1000);
		// two identical path heads with cost extremes and an unseen cell
		repeat (2) begin
			push_beat(16'h0000, 1'b0, 6'd0, 1'b1);
			push_beat(16'h0000, 1'b0, 6'd1, 1'b1);
			push_beat(16'hFFFF, 1'b0, 6'd2, 1'b1);
			push_beat(16'd1234, 1'b1, 6'd3, 1'b1);
		end
		// plane 1 skipped, last plane given as index 63
		push_beat(16'hFFFF, 1'b0, 6'd0, 1'b0);
		push_beat(16'hFFFF, 1'b0, 6'd2, 1'b0);
		push_beat(16'hFFFF, 1'b0, 6'd63, 1'b0);
		// stale cheap entry against a high floor: saturates at zero
		push_beat(16'h0000, 1'b0, 6'd1, 1'b0);
		push_beat(16'hFFFF, 1'b0, 6'd0, 1'b0);
		push_beat(16'hFFFF, 1'b0, 6'd2, 1'b0);
		push_beat(16'h0000, 1'b0, 6'd3, 1'b0);
		// whole pixel unseen
		push_beat(16'hFFFF, 1'b1, 6'd0, 1'b0);
		push_beat(16'h5A5A, 1'b1, 6'd1, 1'b0);
		push_beat(16'h0000, 1'b1, 6'd2, 1'b0);
		push_beat(16'hA5A5, 1'b1, 6'd3, 1'b0);

		// random phases, each with its own settings
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			s_step = draw_step();
			b_step = draw_step();
			u_cost = $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF;
			case (phase)
				0: begin count_set = 8;   send_gap_max = 3;  recv_gap_max = 3;  end
				1: begin
					count_set = 127; s_step = 16'd0; b_step = 16'd0; u_cost = 16'd0;
					send_gap_max = 0; recv_gap_max = 0;
				end
				2: begin
					count_set = 1; s_step = 16'hFFFF; b_step = 16'hFFFF; u_cost = 16'hFFFF;
					send_gap_max = 14; recv_gap_max = 14;
				end
				3: begin count_set = 0;   send_gap_max = 14; recv_gap_max = 0;  end
				4: begin count_set = 64;  send_gap_max = 0;  recv_gap_max = 14; end
				5: begin count_set = 3;   send_gap_max = 14; recv_gap_max = 14; end
				6: begin count_set = 2;   send_gap_max = 5;  recv_gap_max = 5;  end
				default: begin
					count_set = $urandom_range(1, 16);
					send_gap_max = 14;
					recv_gap_max = 3;
				end
			endcase
			write_reg(CFG_PLANE_COUNT, 16'(count_set));
			write_reg(CFG_SMALL_STEP, s_step);
			write_reg(CFG_BIG_STEP, b_step);
			write_reg(CFG_UNSEEN_COST, u_cost);

			// new path first, then mostly in-order pixels with random content
			pushed = 0;
			first  = 1'b1;
			paused = 1'b0;
			while (pushed < PHASE_BEATS) begin
				style = $urandom_range(0, 9);
				style = (style < 7) ? 0 : (style < 9) ? 1 : 2;
				push_pixel(first, style, beats);
				pushed += beats;
				first = 1'b0;
				// sender pause mid-path until every result is back
				if (!paused && pushed >= PHASE_BEATS / 2) begin
					wait_idle();
					paused = 1'b1;
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
